// ----- rtl/pcs_pkg.sv -----
// Shared constants, types and the corner offset table of the voxel splat block.
package pcs_pkg;

  localparam int GRID_ENTRIES     = 4096;
  localparam int ATTR_COUNT       = 4;
  localparam int NODE_TABLE_DEPTH = 64;

  localparam int CORNERS = 8;
  localparam int EW      = $clog2(GRID_ENTRIES);
  localparam int ND_W    = $clog2(NODE_TABLE_DEPTH);
  localparam int BASE_W  = ND_W + 16;
  localparam int WT_W    = 47;
  localparam int SUM_W   = 48;
  localparam int ROW_W   = WT_W + ATTR_COUNT * SUM_W;
  localparam int DIV_NW  = 64;
  localparam int DIV_DW  = 51;
  localparam int RT_W    = 32;

  typedef enum logic [1:0] {
    KIND_SPLAT,
    KIND_READ,
    KIND_LOAD,
    KIND_NONE
  } kind_e;

  typedef enum logic [1:0] {
    STAT_SPLAT,
    STAT_DROP,
    STAT_LOAD,
    STAT_READ
  } status_e;

  typedef enum logic [2:0] {
    CFG_ORG_X,
    CFG_ORG_Y,
    CFG_ORG_Z,
    CFG_SIZE_X,
    CFG_SIZE_Y,
    CFG_SIZE_Z,
    CFG_NX,
    CFG_NY
  } cfg_e;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z,
    AX_NONE
  } axis_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDCELL,
    ST_DIVGO,
    ST_DIVWT,
    ST_BASE,
    ST_BASE2,
    ST_LIM,
    ST_NRD,
    ST_SQ,
    ST_ACC,
    ST_RTGO,
    ST_RTWT,
    ST_RCWT,
    ST_WGO,
    ST_WWT,
    ST_PROD,
    ST_ERD,
    ST_EWR
  } state_e;

  // bit 0 x, bit 1 y, bit 2 z
  function automatic logic [2:0] corner_off(input logic [2:0] j);
    logic [2:0] o;
    unique case (j)
      3'd0: o = 3'b000;
      3'd1: o = 3'b010;
      3'd2: o = 3'b110;
      3'd3: o = 3'b100;
      3'd4: o = 3'b001;
      3'd5: o = 3'b011;
      3'd6: o = 3'b111;
      default: o = 3'b101;
    endcase
    return o;
  endfunction

endpackage

// ----- rtl/point_cloud_idw_voxel_splat_top.sv -----
// Inverse-distance-weighted voxel splatting: sequencer, grid store and node tables.
// A load item or an unknown kind answers in the cycle after start; a read item is
// answered through ST_RDCELL, which registers the grid row. A splat is bound by the
// bit-serial divider (three divisions for the cell, up to eight reciprocals, up to
// eight weights) and the 32-step square root per corner, then a read-modify-write
// (ST_ERD, ST_EWR) on the grid RAM per corner. After reset the grid RAM is swept
// to zero with busy high; configuration writes are taken during that time. done_o
// marks each result for one cycle and cannot be held off.
module point_cloud_idw_voxel_splat_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] attr_a_i,
  input  logic signed [31:0] attr_b_i,
  input  logic signed [31:0] attr_c_i,
  input  logic signed [31:0] attr_d_i,
  input  logic [11:0]        cell_index_i,
  input  logic [1:0]         axis_i,
  input  logic [5:0]         node_index_i,
  input  logic signed [31:0] node_coord_i,
  output logic [1:0]         status_o,
  output logic [11:0]        cell_echo_o,
  output logic [46:0]        weight_total_o,
  output logic signed [47:0] sum_a_o,
  output logic signed [47:0] sum_b_o,
  output logic signed [47:0] sum_c_o,
  output logic signed [47:0] sum_d_o
);
  import pcs_pkg::*;

  localparam logic signed [48:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] ACC_MIN = -49'sh0_8000_0000_0000;
  localparam logic signed [32:0] COMP_MAX = 33'sd2147483647;

  state_e state_q, state_d;

  logic signed [31:0] org_q [3];
  logic [30:0]        size_q [3];
  logic [6:0]         nx_q, ny_q;

  logic [EW-1:0]      clr_q;
  logic [1:0]         ax_q;
  logic [2:0]         j_q;
  logic               drop_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] attr_q [ATTR_COUNT];
  logic [ND_W-1:0]    c_q [3];
  logic [13:0]        nxy_q;
  logic [BASE_W-1:0]  base1_q, base_q;
  logic [61:0]        sqp_q;
  logic [63:0]        acc_q;
  logic               zero_q;
  logic [2:0]         zj_q;
  logic [47:0]        recip_q [CORNERS];
  logic [DIV_DW-1:0]  t_q;
  logic [16:0]        w_q;
  logic signed [32:0] q_q [ATTR_COUNT];
  logic [11:0]        ci_q;

  logic               done_q;
  status_e            status_q;
  logic [11:0]        echo_q;
  logic [WT_W-1:0]    wt_q;
  logic signed [SUM_W-1:0] sum_q [4];

  // datapath nets
  logic               accept;
  logic               read_ok;
  logic               load_ok;
  logic signed [31:0] pos_ax, node_ax;
  logic [30:0]        size_ax;
  logic signed [32:0] dcell;
  logic signed [32:0] diff;
  logic signed [32:0] comp;
  logic [30:0]        mag;
  logic [2:0]         off;
  logic [BASE_W-1:0]  entry;
  logic               lim_fail;
  logic signed [49:0] prod;

  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_num, div_quo;
  logic [DIV_DW-1:0]   div_den;
  logic                rt_start, rt_done;
  logic [RT_W-1:0]     rt_root;

  logic                ram_we;
  logic [EW-1:0]       ram_addr;
  logic [ROW_W-1:0]    ram_wdata, ram_rdata, row_new;

  logic [ND_W-1:0]     node_addr [3];
  logic                node_we [3];
  logic [31:0]         node_rdata [3];

  assign accept  = start && (state_q == ST_IDLE);
  assign read_ok = 32'(cell_index_i) < GRID_ENTRIES;
  assign load_ok = 32'(node_index_i) < NODE_TABLE_DEPTH;

  always_comb begin
    unique case (ax_q)
      2'd0:    begin pos_ax = pos_q[0]; node_ax = node_rdata[0]; size_ax = size_q[0]; end
      2'd1:    begin pos_ax = pos_q[1]; node_ax = node_rdata[1]; size_ax = size_q[1]; end
      default: begin pos_ax = pos_q[2]; node_ax = node_rdata[2]; size_ax = size_q[2]; end
    endcase
  end

  always_comb begin
    unique case (ax_q)
      2'd0:    dcell = {pos_q[0][31], pos_q[0]} - {org_q[0][31], org_q[0]};
      2'd1:    dcell = {pos_q[1][31], pos_q[1]} - {org_q[1][31], org_q[1]};
      default: dcell = {pos_q[2][31], pos_q[2]} - {org_q[2][31], org_q[2]};
    endcase
  end

  assign diff = {pos_ax[31], pos_ax} - {node_ax[31], node_ax};
  always_comb begin
    priority if (diff > COMP_MAX) begin
      comp = COMP_MAX;
    end else if (diff < -COMP_MAX) begin
      comp = -COMP_MAX;
    end else begin
      comp = diff;
    end
  end
  assign mag = comp[32] ? 31'(-comp) : comp[30:0];

  assign off   = corner_off(j_q);
  assign entry = base_q + (off[2] ? BASE_W'(nxy_q) : '0) + (off[0] ? BASE_W'(ny_q) : '0)
               + BASE_W'(off[1]);
  assign lim_fail = (32'(base_q) + 32'(nxy_q) + 32'(ny_q) + 32'd1) >= GRID_ENTRIES;
  assign prod  = $signed({1'b0, w_q}) * attr_q[ax_q];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      node_addr[a] = c_q[a] + ND_W'(off[a]);
      node_we[a]   = 1'b0;
    end
    if (accept && kind_e'(kind_i) == KIND_LOAD) begin
      for (int a = 0; a < 3; a++) begin
        node_addr[a] = ND_W'(node_index_i);
        node_we[a]   = load_ok && (32'(axis_i) == a);
      end
    end
  end

  // grid row update
  always_comb begin
    logic [47:0]        ws;
    logic signed [48:0] s;
    ws = 48'(ram_rdata[WT_W-1:0]) + 48'(w_q);
    row_new[WT_W-1:0] = ws[47] ? {WT_W{1'b1}} : ws[WT_W-1:0];
    for (int a = 0; a < ATTR_COUNT; a++) begin
      s = 49'($signed(ram_rdata[WT_W + a*SUM_W +: SUM_W])) + 49'(q_q[a]);
      priority if (s > ACC_MAX) begin
        row_new[WT_W + a*SUM_W +: SUM_W] = ACC_MAX[SUM_W-1:0];
      end else if (s < ACC_MIN) begin
        row_new[WT_W + a*SUM_W +: SUM_W] = ACC_MIN[SUM_W-1:0];
      end else begin
        row_new[WT_W + a*SUM_W +: SUM_W] = s[SUM_W-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == EW'(GRID_ENTRIES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          unique case (kind_e'(kind_i))
            KIND_SPLAT: state_d = ST_DIVGO;
            KIND_READ:  state_d = read_ok ? ST_RDCELL : ST_IDLE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RDCELL: state_d = ST_IDLE;
      ST_DIVGO: begin
        if (!dcell[32]) state_d = ST_DIVWT;
        else if (ax_q == 2'd2) state_d = ST_BASE;
      end
      ST_DIVWT: if (div_done) state_d = (ax_q == 2'd2) ? ST_BASE : ST_DIVGO;
      ST_BASE:  state_d = ST_BASE2;
      ST_BASE2: state_d = ST_LIM;
      ST_LIM:   state_d = (drop_q || lim_fail) ? ST_IDLE : ST_NRD;
      ST_NRD:   state_d = ST_SQ;
      ST_SQ:    state_d = ST_ACC;
      ST_ACC:   state_d = (ax_q == 2'd2) ? ST_RTGO : ST_SQ;
      ST_RTGO:  state_d = ST_RTWT;
      ST_RTWT: begin
        if (rt_done) begin
          if (rt_root != '0) state_d = ST_RCWT;
          else state_d = (j_q == 3'd7) ? ST_WGO : ST_NRD;
        end
      end
      ST_RCWT:  if (div_done) state_d = (j_q == 3'd7) ? ST_WGO : ST_NRD;
      ST_WGO:   state_d = zero_q ? ST_PROD : ST_WWT;
      ST_WWT:   if (div_done) state_d = ST_PROD;
      ST_PROD:  if (ax_q == 2'(ATTR_COUNT - 1)) state_d = ST_ERD;
      ST_ERD:   state_d = ST_EWR;
      ST_EWR:   state_d = (j_q == 3'd7) ? ST_IDLE : ST_WGO;
      default:  state_d = ST_IDLE;
    endcase
  end

  // unit and memory controls
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    rt_start  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = EW'(entry);
    ram_wdata = row_new;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: ram_addr = EW'(cell_index_i);
      ST_DIVGO: begin
        div_start = !dcell[32];
        div_num   = DIV_NW'(dcell[31:0]);
        div_den   = (size_ax == '0) ? DIV_DW'(1) : DIV_DW'(size_ax);
      end
      ST_RTGO: rt_start = 1'b1;
      ST_RTWT: begin
        div_start = rt_done && (rt_root != '0);
        div_num   = DIV_NW'(1) << 47;
        div_den   = DIV_DW'(rt_root);
      end
      ST_WGO: begin
        div_start = !zero_q;
        div_num   = {recip_q[j_q], 16'b0};
        div_den   = t_q;
      end
      ST_EWR: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      org_q   <= '{default: '0};
      size_q  <= '{default: 31'd65536};
      nx_q    <= 7'd16;
      ny_q    <= 7'd16;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_ORG_X:  org_q[0]  <= cfg_data_i;
          CFG_ORG_Y:  org_q[1]  <= cfg_data_i;
          CFG_ORG_Z:  org_q[2]  <= cfg_data_i;
          CFG_SIZE_X: size_q[0] <= cfg_data_i[30:0];
          CFG_SIZE_Y: size_q[1] <= cfg_data_i[30:0];
          CFG_SIZE_Z: size_q[2] <= cfg_data_i[30:0];
          CFG_NX:     nx_q      <= cfg_data_i[6:0];
          default:    ny_q      <= cfg_data_i[6:0];
        endcase
      end
      if (accept && !(kind_e'(kind_i) == KIND_SPLAT) &&
          !(kind_e'(kind_i) == KIND_READ && read_ok)) begin
        done_q <= 1'b1;
      end
      if (state_q == ST_RDCELL) done_q <= 1'b1;
      if (state_q == ST_LIM && (drop_q || lim_fail)) done_q <= 1'b1;
      if (state_q == ST_EWR && j_q == 3'd7) done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          pos_q[0] <= pos_x_i;
          pos_q[1] <= pos_y_i;
          pos_q[2] <= pos_z_i;
          for (int a = 0; a < ATTR_COUNT; a++) begin
            unique case (a)
              0:       attr_q[a] <= attr_a_i;
              1:       attr_q[a] <= attr_b_i;
              2:       attr_q[a] <= attr_c_i;
              default: attr_q[a] <= attr_d_i;
            endcase
          end
          ax_q   <= '0;
          j_q    <= '0;
          drop_q <= 1'b0;
          ci_q   <= cell_index_i;
          status_q <= STAT_DROP;
          echo_q   <= '0;
          wt_q     <= '0;
          sum_q    <= '{default: '0};
          unique case (kind_e'(kind_i))
            KIND_LOAD: status_q <= STAT_LOAD;
            KIND_READ: begin
              status_q <= STAT_READ;
              echo_q   <= cell_index_i;
            end
            default: ;
          endcase
        end
      end
      ST_RDCELL: begin
        status_q <= STAT_READ;
        echo_q   <= ci_q;
        wt_q     <= ram_rdata[WT_W-1:0];
        for (int a = 0; a < 4; a++) begin
          sum_q[a] <= (a < ATTR_COUNT) ? $signed(ram_rdata[WT_W + a*SUM_W +: SUM_W]) : '0;
        end
      end
      ST_DIVGO: begin
        if (dcell[32]) begin
          drop_q <= 1'b1;
          ax_q   <= ax_q + 1'b1;
        end
      end
      ST_DIVWT: begin
        if (div_done) begin
          if (div_quo >= DIV_NW'(NODE_TABLE_DEPTH - 1)) drop_q <= 1'b1;
          c_q[ax_q] <= div_quo[ND_W-1:0];
          ax_q      <= ax_q + 1'b1;
        end
      end
      ST_BASE: begin
        if (int'(c_q[0]) + 1 >= int'(nx_q) || int'(c_q[1]) + 1 >= int'(ny_q)) drop_q <= 1'b1;
        nxy_q   <= 14'(nx_q * ny_q);
        base1_q <= BASE_W'(BASE_W'(c_q[0]) * BASE_W'(ny_q)) + BASE_W'(c_q[1]);
      end
      ST_BASE2: base_q <= BASE_W'(BASE_W'(c_q[2]) * BASE_W'(nxy_q)) + base1_q;
      ST_LIM: begin
        j_q    <= '0;
        t_q    <= '0;
        zero_q <= 1'b0;
        status_q <= STAT_DROP;
        echo_q   <= '0;
        wt_q     <= '0;
        sum_q    <= '{default: '0};
      end
      ST_NRD: begin
        ax_q  <= '0;
        acc_q <= '0;
      end
      ST_SQ:  sqp_q <= 62'(mag) * 62'(mag);
      ST_ACC: begin
        acc_q <= acc_q + 64'(sqp_q);
        ax_q  <= ax_q + 1'b1;
      end
      ST_RTWT: begin
        if (rt_done && rt_root == '0) begin
          if (!zero_q) begin
            zero_q <= 1'b1;
            zj_q   <= j_q;
          end
          j_q <= j_q + 1'b1;
        end
      end
      ST_RCWT: begin
        if (div_done) begin
          recip_q[j_q] <= div_quo[47:0];
          t_q          <= t_q + DIV_DW'(div_quo[47:0]);
          j_q          <= j_q + 1'b1;
        end
      end
      ST_WGO: begin
        ax_q <= '0;
        if (zero_q) w_q <= (j_q == zj_q) ? 17'h10000 : '0;
      end
      ST_WWT: if (div_done) w_q <= div_quo[16:0];
      ST_PROD: begin
        q_q[ax_q] <= prod[48:16];
        ax_q      <= ax_q + 1'b1;
      end
      ST_EWR: begin
        j_q <= j_q + 1'b1;
        status_q <= STAT_SPLAT;
      end
      default: ;
    endcase
  end

  pcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  pcs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .rad_i   (acc_q),
    .done_o  (rt_done),
    .root_o  (rt_root)
  );

  pcs_ram #(.WIDTH(ROW_W), .DEPTH(GRID_ENTRIES)) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  for (genvar a = 0; a < 3; a++) begin : g_node
    pcs_ram #(.WIDTH(32), .DEPTH(NODE_TABLE_DEPTH)) u_node (
      .clk_i   (clk_i),
      .we_i    (node_we[a]),
      .addr_i  (node_addr[a]),
      .wdata_i (node_coord_i),
      .rdata_o (node_rdata[a])
    );
  end

  assign busy           = state_q != ST_IDLE;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign cell_echo_o    = echo_q;
  assign weight_total_o = wt_q;
  assign sum_a_o        = sum_q[0];
  assign sum_b_o        = sum_q[1];
  assign sum_c_o        = sum_q[2];
  assign sum_d_o        = sum_q[3];

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVWT || state_q == ST_RCWT || state_q == ST_WWT))
    else $error("divider finished outside a wait state");

  a_rt_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_done |-> state_q == ST_RTWT)
    else $error("square root finished outside its wait state");

  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EWR |-> $past(state_q) == ST_ERD)
    else $error("grid write-back without a preceding read");

  a_beat_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted beat neither answered nor in progress");

endmodule

// ----- rtl/pcs_ram.sv -----
// Generic single-port RAM with registered read.
module pcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pcs_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module pcs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pcs_pkg::DIV_NW-1:0] num_i,
  input  logic [pcs_pkg::DIV_DW-1:0] den_i,
  output logic                       done_o,
  output logic [pcs_pkg::DIV_NW-1:0] quo_o
);
  import pcs_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] num_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_q, num_q[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DIV_NW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? DIV_DW'(rem_sh - {1'b0, den_q}) : DIV_DW'(rem_sh);
      num_q <= {num_q[DIV_NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ----- rtl/pcs_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
module pcs_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [2*pcs_pkg::RT_W-1:0] rad_i,
  output logic                     done_o,
  output logic [pcs_pkg::RT_W-1:0] root_o
);
  import pcs_pkg::*;

  localparam int CNT_W = $clog2(RT_W + 1);

  logic [2*RT_W-1:0] rad_q;
  logic [RT_W+1:0]   rem_q;
  logic [RT_W-1:0]   root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [RT_W+1:0]   rem_sh;
  logic [RT_W+1:0]   trial;
  logic              fits;

  assign rem_sh = {rem_q[RT_W-1:0], rad_q[2*RT_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(RT_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RT_W-2:0], fits};
      rad_q  <= {rad_q[2*RT_W-3:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
